[rtl/core/prs_pkg.sv]
package prs_pkg;

  // bank geometry, fixed by the widths of the rank, bank and mask fields
  localparam int NUM_RANKS       = 2;
  localparam int NUM_BANKS       = 8;
  localparam int BANKS_PER_GROUP = 2;
  localparam int NUM_GROUPS      = NUM_BANKS / BANKS_PER_GROUP;
  localparam int NUM_SLOTS       = NUM_RANKS * NUM_GROUPS;

  localparam int COUNT_BITS_DEF  = 8;

  localparam int OP_W    = 2;
  localparam int RANK_W  = 1;
  localparam int BANK_W  = 3;
  localparam int MASK_W  = NUM_RANKS * NUM_BANKS;
  localparam int GRP_W   = $clog2(NUM_GROUPS);
  localparam int SLOT_W  = RANK_W + GRP_W;
  localparam int SUB_W   = (BANKS_PER_GROUP > 1) ? $clog2(BANKS_PER_GROUP) : 1;
  localparam int KIND_W  = 2;
  localparam int THR_W   = 8;

  // configuration port
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_REFRESH_EN   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRECHARGE_EN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
  localparam logic [OP_W-1:0] OP_ISSUE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRECHARGE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REFRESH   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd3;

  typedef struct packed {
    logic              refresh_en;
    logic              precharge_en;
    logic [THR_W-1:0]  threshold;
  } cfg_t;

  typedef struct packed {
    logic              latch_item;
    logic              pulse;
    logic              clear;
    logic              scan_sel;
    logic              scan_step;
    logic              found;
    logic              issue;
    logic              pre_pop;
    logic              load_out;
    logic [KIND_W-1:0] out_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_due;
    logic scan_end;
    logic pre_pending;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/prs_if.sv]
interface prs_in_if;
  import prs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [RANK_W-1:0] rank_sel;
  logic [BANK_W-1:0] bank_sel;
  logic [MASK_W-1:0] open_banks;

  modport source (output valid, operation, rank_sel, bank_sel, open_banks, input ready);
  modport sink   (input valid, operation, rank_sel, bank_sel, open_banks, output ready);
endinterface

interface prs_out_if;
  import prs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] command_kind;
  logic [RANK_W-1:0] cmd_rank;
  logic [BANK_W-1:0] cmd_bank;
  logic              group_needs;
  logic              group_queued;
  logic              last;

  modport source (output valid, command_kind, cmd_rank, cmd_bank, group_needs, group_queued,
                  last, input ready);
  modport sink   (input valid, command_kind, cmd_rank, cmd_bank, group_needs, group_queued,
                  last, output ready);
endinterface

[rtl/core/postponed_refresh_scheduler.sv]
// postponed refresh scheduler: keeps an owed-refresh count for every rank and bank group,
// with needs and queued flags per group. an input transaction is a pulse (one more owed
// refresh), an issue (round-robin search for the first group at threshold, then 0 or more
// precharges for its open banks followed by one refresh) or a clear of the queued flags.
// items are handled one at a time by a state machine over a small datapath. a pulse or
// clear is accepted, updates its group, then loads its status result into the output
// register. an issue is accepted, then the scan examines group slots (1 to 8, testing one
// counter per cycle), an update step books the group found and its results go out in turn
// (up to 2 precharges and a refresh); a miss or an undefined code gives one empty result.
// the next item is taken as soon as the last result of the current one sits in the
// output register, and results wait there while the sink stalls. the counters, flags and
// round-robin pointers are cleared by reset directly; configuration is written through
// an apb-style port with pready tied high and should only change while the block is idle.
module postponed_refresh_scheduler #(
  parameter int COUNT_BITS = prs_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  prs_in_if.sink                      in_chan,
  prs_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prs_pkg::ADDR_W-1:0]  paddr,
  input  logic [prs_pkg::DATA_W-1:0]  pwdata,
  output logic [prs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import prs_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file: enable, precharge enable, threshold
  prs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: accepts items, walks the scan, paces results into the output register
  prs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_operation (in_chan.operation),
    .in_ready     (in_chan.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // counters, flags, pointers and the output register
  prs_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_rank_sel      (in_chan.rank_sel),
    .in_bank_sel      (in_chan.bank_sel),
    .in_open_banks    (in_chan.open_banks),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_command_kind (out_chan.command_kind),
    .out_cmd_rank     (out_chan.cmd_rank),
    .out_cmd_bank     (out_chan.cmd_bank),
    .out_group_needs  (out_chan.group_needs),
    .out_group_queued (out_chan.group_queued),
    .out_last         (out_chan.last)
  );

endmodule

[rtl/core/prs_cfg.sv]
module prs_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [prs_pkg::ADDR_W-1:0] paddr,
  input  logic [prs_pkg::DATA_W-1:0] pwdata,
  output logic [prs_pkg::DATA_W-1:0] prdata,
  output logic                    pready,
  output prs_pkg::cfg_t           cfg
);
  import prs_pkg::*;

  logic             refresh_en_r;
  logic             precharge_en_r;
  logic [THR_W-1:0] threshold_r;
  logic             wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_en_r   <= 1'b0;
      precharge_en_r <= 1'b1;
      threshold_r    <= THR_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_REFRESH_EN:   refresh_en_r   <= pwdata[0];
        REG_PRECHARGE_EN: precharge_en_r <= pwdata[0];
        REG_THRESHOLD:    threshold_r    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REFRESH_EN:   prdata = DATA_W'(refresh_en_r);
      REG_PRECHARGE_EN: prdata = DATA_W'(precharge_en_r);
      REG_THRESHOLD:    prdata = DATA_W'(threshold_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.refresh_en   = refresh_en_r;
  assign cfg.precharge_en = precharge_en_r;
  assign cfg.threshold    = threshold_r;

endmodule

[rtl/core/prs_dp.sv]
module prs_dp #(
  parameter int COUNT_BITS = prs_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prs_pkg::cfg_t                cfg,
  input  prs_pkg::dp_cmd_t             cmd,
  output prs_pkg::dp_sts_t             sts,
  input  logic [prs_pkg::RANK_W-1:0]   in_rank_sel,
  input  logic [prs_pkg::BANK_W-1:0]   in_bank_sel,
  input  logic [prs_pkg::MASK_W-1:0]   in_open_banks,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [prs_pkg::KIND_W-1:0]   out_command_kind,
  output logic [prs_pkg::RANK_W-1:0]   out_cmd_rank,
  output logic [prs_pkg::BANK_W-1:0]   out_cmd_bank,
  output logic                         out_group_needs,
  output logic                         out_group_queued,
  output logic                         out_last
);
  import prs_pkg::*;

  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  logic [COUNT_BITS-1:0]      count_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       needs_r;
  logic [NUM_SLOTS-1:0]       queued_r;
  logic [SLOT_W-1:0]          ptr_r;
  logic [SLOT_W-1:0]          scan_i_r;
  logic [SLOT_W-1:0]          cur_slot_r;
  logic [MASK_W-1:0]          open_r;
  logic [BANKS_PER_GROUP-1:0] pre_mask_r;

  logic                       out_valid_r;
  logic [KIND_W-1:0]          out_kind_r;
  logic [RANK_W-1:0]          out_rank_r;
  logic [BANK_W-1:0]          out_bank_r;
  logic                       out_needs_r;
  logic                       out_queued_r;
  logic                       out_last_r;

  logic [SLOT_W-1:0]          scan_slot;
  logic [RANK_W-1:0]          scan_rank;
  logic [GRP_W-1:0]           scan_grp;
  logic [SLOT_W-1:0]          rd_slot;
  logic [COUNT_BITS-1:0]      rd_cnt;
  logic [COUNT_BITS-1:0]      cnt_inc;
  logic [COUNT_BITS-1:0]      cnt_dec;
  logic                       due_rd;
  logic                       due_inc;
  logic                       due_dec;
  logic [RANK_W-1:0]          cur_rank;
  logic [GRP_W-1:0]           cur_grp;
  logic [BANK_W-1:0]          head_bank;
  logic [SUB_W-1:0]           pre_sub;
  logic [BANK_W-1:0]          pre_bank;
  logic [SLOT_W-1:0]          item_slot;

  function automatic logic is_due(input logic en, input logic [COUNT_BITS-1:0] c,
                                  input logic [THR_W-1:0] thr);
    return en && (CMP_W'(c) >= CMP_W'(thr));
  endfunction

  // round-robin slot: rank offset then group offset, both wrapping
  assign scan_rank = ptr_r[SLOT_W-1 -: RANK_W] + scan_i_r[SLOT_W-1 -: RANK_W];
  assign scan_grp  = ptr_r[GRP_W-1:0] + scan_i_r[GRP_W-1:0];
  assign scan_slot = {scan_rank, scan_grp};

  assign rd_slot = cmd.scan_sel ? scan_slot : cur_slot_r;
  assign rd_cnt  = count_r[rd_slot];
  assign cnt_inc = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  assign cnt_dec = (rd_cnt == '0) ? rd_cnt : rd_cnt - 1'b1;
  assign due_rd  = is_due(cfg.refresh_en, rd_cnt, cfg.threshold);
  assign due_inc = is_due(cfg.refresh_en, cnt_inc, cfg.threshold);
  assign due_dec = is_due(cfg.refresh_en, cnt_dec, cfg.threshold);

  assign item_slot = {in_rank_sel, GRP_W'(in_bank_sel / BANKS_PER_GROUP)};
  assign cur_rank  = cur_slot_r[SLOT_W-1 -: RANK_W];
  assign cur_grp   = cur_slot_r[GRP_W-1:0];
  assign head_bank = BANK_W'(cur_grp * BANKS_PER_GROUP);

  // lowest pending precharge goes out first
  always_comb begin
    pre_sub = '0;
    for (int t = BANKS_PER_GROUP - 1; t >= 0; t--) begin
      if (pre_mask_r[t]) pre_sub = SUB_W'(t);
    end
  end
  assign pre_bank = head_bank + BANK_W'(pre_sub);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) count_r[s] <= '0;
      needs_r  <= '0;
      queued_r <= '0;
      ptr_r    <= '0;
      scan_i_r <= '0;
    end else begin
      if (cmd.latch_item) scan_i_r <= '0;
      else if (cmd.scan_step) scan_i_r <= scan_i_r + 1'b1;
      if (cmd.pulse) begin
        count_r[cur_slot_r] <= cnt_inc;
        if (due_inc) needs_r[cur_slot_r] <= 1'b1;
      end
      if (cmd.clear) queued_r[cur_slot_r] <= 1'b0;
      if (cmd.issue) begin
        count_r[cur_slot_r]  <= cnt_dec;
        queued_r[cur_slot_r] <= 1'b1;
        if (!due_dec) needs_r[cur_slot_r] <= 1'b0;
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      cur_slot_r <= item_slot;
      open_r     <= in_open_banks;
    end else if (cmd.found) begin
      cur_slot_r <= scan_slot;
    end
    if (cmd.issue) begin
      pre_mask_r <= cfg.precharge_en ?
                    open_r[cur_slot_r * BANKS_PER_GROUP +: BANKS_PER_GROUP] : '0;
    end else if (cmd.pre_pop) begin
      pre_mask_r[pre_sub] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r <= cmd.out_kind;
      case (cmd.out_kind)
        KIND_PRECHARGE: begin
          out_rank_r   <= cur_rank;
          out_bank_r   <= pre_bank;
          out_needs_r  <= needs_r[cur_slot_r];
          out_queued_r <= queued_r[cur_slot_r];
          out_last_r   <= 1'b0;
        end
        KIND_NONE: begin
          out_rank_r   <= '0;
          out_bank_r   <= '0;
          out_needs_r  <= 1'b0;
          out_queued_r <= 1'b0;
          out_last_r   <= 1'b1;
        end
        default: begin
          out_rank_r   <= cur_rank;
          out_bank_r   <= head_bank;
          out_needs_r  <= needs_r[cur_slot_r];
          out_queued_r <= queued_r[cur_slot_r];
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  assign sts.slot_due    = due_rd;
  assign sts.scan_end    = (scan_i_r == '1);
  assign sts.pre_pending = |pre_mask_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_command_kind = out_kind_r;
  assign out_cmd_rank     = out_rank_r;
  assign out_cmd_bank     = out_bank_r;
  assign out_group_needs  = out_needs_r;
  assign out_group_queued = out_queued_r;
  assign out_last         = out_last_r;

endmodule

[rtl/core/prs_ctrl.sv]
module prs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [prs_pkg::OP_W-1:0]   in_operation,
  output logic                       in_ready,
  input  prs_pkg::dp_sts_t           sts,
  output prs_pkg::dp_cmd_t           cmd
);
  import prs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PULSE  = 8'b0000_0010,
    S_CLEAR  = 8'b0000_0100,
    S_STATUS = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_ISSUE  = 8'b0010_0000,
    S_EMIT   = 8'b0100_0000,
    S_NONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch_item = 1'b1;
          case (in_operation)
            OP_PULSE: state_nxt = S_PULSE;
            OP_ISSUE: state_nxt = S_SCAN;
            OP_CLEAR: state_nxt = S_CLEAR;
            default:  state_nxt = S_NONE;
          endcase
        end
      end
      S_PULSE: begin
        cmd.pulse = 1'b1;
        state_nxt = S_STATUS;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_STATUS;
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_STATUS;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_sel = 1'b1;
        if (sts.slot_due) begin
          cmd.found = 1'b1;
          state_nxt = S_ISSUE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_end) state_nxt = S_NONE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.pre_pending) begin
            cmd.out_kind = KIND_PRECHARGE;
            cmd.pre_pop  = 1'b1;
          end else begin
            cmd.out_kind = KIND_REFRESH;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_NONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_NONE;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import prs_pkg::*;

  // operation code the block does not define, must come back as an empty result
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int COUNT_MAX     = (1 << COUNT_BITS_DEF) - 1;
  localparam int IDLE_PCT      = 14;      // chance of a bubble per cycle on either side
  localparam int HOLD_CYCLES   = 80;      // long sink stall, fills the block up
  localparam int SETTLE_CYCLES = 12;      // quiet wait after the last owed result comes back
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 8;
  localparam int SAT_PULSES    = 256;     // one past what pins a group counter at its max

  // one result transaction
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RANK_W-1:0] rank;
    logic [BANK_W-1:0] bank;
    logic              needs;
    logic              queued;
    logic              last;
  } cmd_t;

  localparam cmd_t NO_CMD    = '0;
  localparam cmd_t WANT_NONE = '{KIND_NONE, 1'b0, 3'd0, 1'b0, 1'b0, 1'b1};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             what;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [THR_W-1:0]      reg_val;
    logic [OP_W-1:0]       op;
    logic [RANK_W-1:0]     rank;
    logic [BANK_W-1:0]     bank;
    logic [MASK_W-1:0]     mask;
    bit                    typed;    // use want below instead of the predictor
    cmd_t                  want;
  } dir_row_t;

  localparam int N_DIR = 29;

  // directed part: reset state first, then each register, extremes of the threshold,
  // threshold zero, precharge off, refresh off, and the undefined operation
  dir_row_t dir_rows [N_DIR] = '{
    // reset config: refresh off, so nothing is ever due
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'h0000, 1'b1, WANT_NONE},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b1,
      '{KIND_STATUS, 1'b0, 3'd0, 1'b0, 1'b0, 1'b1}},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_UNUSED, 1'b1, 3'd7, 16'hffff, 1'b1, WANT_NONE},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_CLEAR, 1'b1, 3'd7, 16'h0000, 1'b1,
      '{KIND_STATUS, 1'b1, 3'd6, 1'b0, 1'b0, 1'b1}},
    // refresh on, threshold 1
    '{ROW_CFG,  REG_REFRESH_EN, 8'd1, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b0, 3'd1, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b1, 3'd7, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'hffff, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_CLEAR, 1'b0, 3'd1, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'h0300, 1'b0, NO_CMD},
    // precharge off
    '{ROW_CFG,  REG_PRECHARGE_EN, 8'd0, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b1, 3'd2, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b1, 3'd3, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'hffff, 1'b0, NO_CMD},
    // precharge back on, threshold at its top
    '{ROW_CFG,  REG_PRECHARGE_EN, 8'd1, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_CFG,  REG_THRESHOLD, 8'd255, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b0, 3'd5, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'hffff, 1'b0, NO_CMD},
    // threshold zero: every group is due, counters bottom out at zero
    '{ROW_CFG,  REG_THRESHOLD, 8'd0, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'hffff, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'h5555, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'haaaa, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_CLEAR, 1'b0, 3'd6, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b1, 3'd4, 16'h0000, 1'b0, NO_CMD},
    // refresh off again, an issue can only come back empty
    '{ROW_CFG,  REG_THRESHOLD, 8'd1, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_CFG,  REG_REFRESH_EN, 8'd0, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD},
    '{ROW_ITEM, REG_REFRESH_EN, 8'd0, OP_ISSUE, 1'b0, 3'd0, 16'hffff, 1'b1, WANT_NONE},
    '{ROW_CFG,  REG_REFRESH_EN, 8'd1, OP_PULSE, 1'b0, 3'd0, 16'h0000, 1'b0, NO_CMD}
  };

  logic clk;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  prs_in_if  in_chan ();
  prs_out_if out_chan ();

  postponed_refresh_scheduler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // scheduler state as the testbench sees it
  logic [COUNT_BITS_DEF-1:0] owed_cnt  [NUM_RANKS][NUM_GROUPS];
  logic                      needs_q   [NUM_RANKS][NUM_BANKS];
  logic                      queued_q  [NUM_RANKS][NUM_BANKS];
  int                        rr_rank;
  int                        rr_bank;
  cfg_t                      cfg_mirror;

  cmd_t step_cmds[$];      // results of the item just accepted
  cmd_t pending_cmds[$];   // results still owed by the block, oldest first

  int   err_cnt;
  int   cycle_cnt;
  int   n_in, n_out, n_refresh, n_precharge, n_status, n_none, n_cfg;
  bit   calm;              // no bubbles on either side while set
  int   hold_gen;          // bumped by the stimulus to ask for a long sink stall
  int   hold_seen;
  int   hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------

  function automatic bit group_due(input int r, input int g);
    return cfg_mirror.refresh_en && (owed_cnt[r][g] >= cfg_mirror.threshold);
  endfunction

  // works out the results of one accepted transaction and updates the state copy
  function automatic void refresh_sched_step(input logic [OP_W-1:0]   op,
                                             input logic [RANK_W-1:0] rk,
                                             input logic [BANK_W-1:0] bk,
                                             input logic [MASK_W-1:0] mask);
    int   grp, head, r, j, b, n_pre, ri, gi, t;
    int   pre_bank [BANKS_PER_GROUP];
    bit   found;
    cmd_t c;
    step_cmds.delete();
    case (op)
      OP_PULSE, OP_CLEAR: begin
        grp  = int'(bk) / BANKS_PER_GROUP;
        head = grp * BANKS_PER_GROUP;
        if (op == OP_PULSE) begin
          // saturating owed count
          if (owed_cnt[rk][grp] != COUNT_BITS_DEF'(COUNT_MAX))
            owed_cnt[rk][grp] = owed_cnt[rk][grp] + 1'b1;
          if (group_due(rk, grp))
            for (t = 0; t < BANKS_PER_GROUP; t++) needs_q[rk][head + t] = 1'b1;
        end else begin
          for (t = 0; t < BANKS_PER_GROUP; t++) queued_q[rk][head + t] = 1'b0;
        end
        c = '{KIND_STATUS, rk, BANK_W'(head), needs_q[rk][head], queued_q[rk][head], 1'b1};
        step_cmds.push_back(c);
      end
      OP_ISSUE: begin
        found = 1'b0;
        for (ri = 0; ri < NUM_RANKS && !found; ri++) begin
          r = (rr_rank + ri) % NUM_RANKS;
          for (gi = 0; gi < NUM_GROUPS && !found; gi++) begin
            j   = (rr_bank + gi * BANKS_PER_GROUP) % NUM_BANKS;
            grp = j / BANKS_PER_GROUP;
            if (group_due(r, grp)) begin
              found = 1'b1;
              n_pre = 0;
              if (cfg_mirror.precharge_en)
                for (t = 0; t < BANKS_PER_GROUP; t++) begin
                  b = (t + j) % NUM_BANKS;
                  if (mask[r * NUM_BANKS + b]) begin
                    pre_bank[n_pre] = b;
                    n_pre++;
                  end
                end
              for (t = 0; t < BANKS_PER_GROUP; t++) queued_q[r][(t + j) % NUM_BANKS] = 1'b1;
              // booked as done, never below zero
              if (owed_cnt[r][grp] != '0) owed_cnt[r][grp] = owed_cnt[r][grp] - 1'b1;
              if (!group_due(r, grp))
                for (t = 0; t < BANKS_PER_GROUP; t++) needs_q[r][j + t] = 1'b0;
              rr_bank += BANKS_PER_GROUP;
              if (rr_bank >= NUM_BANKS) begin
                rr_bank = 0;
                rr_rank = (rr_rank + 1) % NUM_RANKS;
              end
              for (t = 0; t < n_pre; t++) begin
                c = '{KIND_PRECHARGE, RANK_W'(r), BANK_W'(pre_bank[t]),
                      needs_q[r][j], queued_q[r][j], 1'b0};
                step_cmds.push_back(c);
              end
              c = '{KIND_REFRESH, RANK_W'(r), BANK_W'(j), needs_q[r][j], queued_q[r][j], 1'b1};
              step_cmds.push_back(c);
            end
          end
        end
        if (!found) step_cmds.push_back(WANT_NONE);
      end
      default: step_cmds.push_back(WANT_NONE);
    endcase
  endfunction

  // ---------------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------------

  // offers one transaction, with random bubbles ahead of it, and books its results
  task automatic send_op(input logic [OP_W-1:0]   op,
                         input logic [RANK_W-1:0] rk,
                         input logic [BANK_W-1:0] bk,
                         input logic [MASK_W-1:0] mask,
                         input bit                typed,
                         input cmd_t              want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.operation  <= op;
    in_chan.rank_sel   <= rk;
    in_chan.bank_sel   <= bk;
    in_chan.open_banks <= mask;
    do @(posedge clk); while (!in_chan.ready);
    n_in++;
    refresh_sched_step(op, rk, bk, mask);
    if (typed) pending_cmds.push_back(want);
    else foreach (step_cmds[k]) pending_cmds.push_back(step_cmds[k]);
  endtask

  // sender goes quiet until every owed result is back and the block has settled
  task automatic drain_block();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------------

  task automatic cfg_access(input  bit                   wr,
                            input  logic [REG_IDX_W-1:0] idx,
                            input  logic [DATA_W-1:0]    wdata,
                            output logic [DATA_W-1:0]    rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_REFRESH_EN:   return DATA_W'(cfg_mirror.refresh_en);
      REG_PRECHARGE_EN: return DATA_W'(cfg_mirror.precharge_en);
      REG_THRESHOLD:    return DATA_W'(cfg_mirror.threshold);
      default:          return '0;
    endcase
  endfunction

  task automatic cfg_check(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== reg_value(idx)) begin
      err_cnt++;
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, idx, reg_value(idx), rd);
    end
  endtask

  // only called with the block idle
  task automatic cfg_set(input logic [REG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    logic [DATA_W-1:0] rd;
    cfg_access(1'b1, idx, DATA_W'(val), rd);
    n_cfg++;
    case (idx)
      REG_REFRESH_EN:   cfg_mirror.refresh_en   = val[0];
      REG_PRECHARGE_EN: cfg_mirror.precharge_en = val[0];
      REG_THRESHOLD:    cfg_mirror.threshold    = val;
      default: ;
    endcase
    cfg_check(idx);
  endtask

  // ---------------------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------------------

  // sink ready: random bubbles, a calm stretch, and the long stall on request
  initial begin
    out_chan.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_seen != hold_gen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // compare each result transaction with the oldest owed one
  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_out++;
      case (out_chan.command_kind)
        KIND_REFRESH:   n_refresh++;
        KIND_PRECHARGE: n_precharge++;
        KIND_STATUS:    n_status++;
        default:        n_none++;
      endcase
      if (pending_cmds.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected nothing, got kind %0d rank %0d bank %0d",
                 $time, out_chan.command_kind, out_chan.cmd_rank, out_chan.cmd_bank);
      end else begin
        want = pending_cmds.pop_front();
        check_field("command_kind", want.kind,   out_chan.command_kind);
        check_field("cmd_rank",     want.rank,   out_chan.cmd_rank);
        check_field("cmd_bank",     want.bank,   out_chan.cmd_bank);
        check_field("group_needs",  want.needs,  out_chan.group_needs);
        check_field("group_queued", want.queued, out_chan.group_queued);
        check_field("last",         want.last,   out_chan.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still owed", $time, pending_cmds.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------------

  function automatic logic [MASK_W-1:0] rand_mask();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return MASK_W'($urandom);
  endfunction

  function automatic logic [THR_W-1:0] rand_threshold();
    int roll;
    roll = $urandom_range(19);
    if (roll < 14) return THR_W'($urandom_range(4, 1));
    if (roll < 17) return THR_W'($urandom_range(255, 1));
    return THR_W'(255);
  endfunction

  initial begin
    logic [OP_W-1:0] op;
    int              roll;
    // everything driven to a known value from time zero
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.operation  = OP_PULSE;
    in_chan.rank_sel   = '0;
    in_chan.bank_sel   = '0;
    in_chan.open_banks = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    n_in = 0; n_out = 0; n_refresh = 0; n_precharge = 0; n_status = 0; n_none = 0;
    n_cfg = 0;
    calm = 1'b0;
    hold_gen = 0;

    // state copy after reset
    foreach (owed_cnt[r, g]) owed_cnt[r][g] = '0;
    foreach (needs_q[r, b]) begin
      needs_q[r][b]  = 1'b0;
      queued_q[r][b] = 1'b0;
    end
    rr_rank = 0;
    rr_bank = 0;
    cfg_mirror.refresh_en   = 1'b0;
    cfg_mirror.precharge_en = 1'b1;
    cfg_mirror.threshold    = THR_W'(1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers must read back their reset values
    cfg_check(REG_REFRESH_EN);
    cfg_check(REG_PRECHARGE_EN);
    cfg_check(REG_THRESHOLD);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].what == ROW_CFG) begin
        drain_block();
        cfg_set(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_op(dir_rows[i].op, dir_rows[i].rank, dir_rows[i].bank, dir_rows[i].mask,
                dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // pin one counter at its maximum with the threshold at its top, then work it down;
    // the pulse run doubles as a long stretch at full rate on both sides
    drain_block();
    cfg_set(REG_THRESHOLD, THR_W'(255));
    calm = 1'b1;
    for (int i = 0; i < SAT_PULSES; i++)
      send_op(OP_PULSE, 1'b1, 3'd5, '0, 1'b0, NO_CMD);
    calm = 1'b0;
    send_op(OP_ISSUE, 1'b0, 3'd0, '1, 1'b0, NO_CMD);
    send_op(OP_PULSE, 1'b1, 3'd4, '0, 1'b0, NO_CMD);
    send_op(OP_ISSUE, 1'b0, 3'd0, 16'h2000, 1'b0, NO_CMD);
    send_op(OP_ISSUE, 1'b0, 3'd0, '1, 1'b0, NO_CMD);

    // random phases, each with its own configuration
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_block();
      if (ph == 0) begin
        cfg_set(REG_REFRESH_EN, THR_W'(1));
        cfg_set(REG_PRECHARGE_EN, THR_W'(1));
        cfg_set(REG_THRESHOLD, THR_W'(1));
      end else begin
        cfg_set(REG_REFRESH_EN, THR_W'($urandom_range(9) != 0));
        cfg_set(REG_PRECHARGE_EN, THR_W'($urandom_range(3) != 0));
        cfg_set(REG_THRESHOLD, rand_threshold());
      end
      calm = (ph == 3);   // one stretch at full rate on both sides
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sink stalls long while items keep coming
        if (ph == 2 && i == 2) hold_gen++;
        // sender waits for the block to empty out mid-phase
        if (ph == 4 && i == 4) drain_block();
        roll = $urandom_range(99);
        if (roll < 45)      op = OP_PULSE;
        else if (roll < 80) op = OP_ISSUE;
        else if (roll < 95) op = OP_CLEAR;
        else                op = OP_UNUSED;
        send_op(op, RANK_W'($urandom_range(1)), BANK_W'($urandom_range(7)), rand_mask(),
                1'b0, NO_CMD);
      end
      calm = 1'b0;
    end

    drain_block();
    $display("covered %0d transactions in, %0d out: %0d refresh, %0d precharge, %0d status,",
             n_in, n_out, n_refresh, n_precharge, n_status);
    $display("%0d empty; %0d register writes over directed, saturation and random phases",
             n_none, n_cfg);
    if (err_cnt == 0 && pending_cmds.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/prs_pkg.sv
rtl/core/prs_if.sv
rtl/core/prs_cfg.sv
rtl/core/prs_dp.sv
rtl/core/prs_ctrl.sv
rtl/core/postponed_refresh_scheduler.sv
test/testbench.sv
